/* rtl/dds_rws_pkg.sv */
// ============================================================================
// dds_rws_pkg
// Shared types and constants of the DDS register write serialiser.
// ============================================================================
package dds_rws_pkg;

  localparam logic [1:0] MODE_FREQ  = 2'd0;
  localparam logic [1:0] MODE_AMP   = 2'd1;
  localparam logic [1:0] MODE_PHASE = 2'd2;

  localparam logic [7:0] ADDR_CSR = 8'h00;
  localparam logic [7:0] ADDR_FTW = 8'h04;
  localparam logic [7:0] ADDR_POW = 8'h05;
  localparam logic [7:0] ADDR_ACR = 8'h06;

  localparam logic [15:0] AMP_ENABLE = 16'h1000;
  localparam logic [28:0] DDS_CLK    = 29'd500000000;
  localparam logic [31:0] FTW_SAT    = 32'hFFFFFFFF;

  // tuning word = (value * 2^50 / 2^50) * 2^32 / clock, via ceil(2^82 / clock)
  // scaled by 2^-50; exact floor for every value below the clock
  localparam int RECIP_W    = 54;
  localparam int RECIP_HALF = 27;
  localparam logic [RECIP_W-1:0] FTW_RECIP =
    RECIP_W'(((83'd1 << 82) + 83'(DDS_CLK) - 83'd1) / 83'(DDS_CLK));

  localparam int STREAM_W  = 56;
  localparam int IDX_W     = $clog2(STREAM_W);

  localparam logic [IDX_W-1:0] LAST_IDX_FTW  = IDX_W'(STREAM_W - 1);
  localparam logic [IDX_W-1:0] LAST_IDX_AMP  = IDX_W'(STREAM_W - 9);
  localparam logic [IDX_W-1:0] LAST_IDX_POW  = IDX_W'(STREAM_W - 17);
  localparam logic [IDX_W-1:0] FRAME1_LAST   = IDX_W'(15);

  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // data is left aligned: unused low bytes are never shifted out
  typedef struct packed {
    logic [7:0]       chan;
    logic [7:0]       addr;
    logic [31:0]      data;
    logic [IDX_W-1:0] last_idx;
  } frame_t;

endpackage

/* rtl/dds_rws_front.sv */
// ============================================================================
// dds_rws_front
// Command intake: picks the register, builds the data word and forms the
// tuning word for frequency commands by a three-step reciprocal multiply.
// ============================================================================
module dds_rws_front import dds_rws_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode,
  input  logic [7:0]  chan,
  input  logic [28:0] value,
  output frame_t      res,
  output logic        res_valid,
  input  logic        res_ready
);

  localparam logic [1:0] STEP_LO  = 2'd0;
  localparam logic [1:0] STEP_HI  = 2'd1;
  localparam logic [1:0] STEP_SUM = 2'd2;

  logic        busy_r, busy_nxt;
  logic        res_valid_r, res_valid_nxt;
  frame_t      res_r, res_nxt;
  logic [28:0] val_r, val_nxt;
  logic [1:0]  step_r, step_nxt;
  logic [28:0] lo_r, lo_nxt;
  logic [55:0] hi_r, hi_nxt;

  logic                  res_free;
  logic                  accept;
  logic [RECIP_HALF-1:0] k_half;
  logic [55:0]           prod;
  logic [55:0]           sum;

  assign res_free  = !res_valid_r || res_ready;
  assign full      = busy_r || !res_free;
  assign accept    = push && !full;
  assign res       = res_r;
  assign res_valid = res_valid_r;

  // one 29 x 27 product per step, low half first
  assign k_half = (step_r == STEP_LO) ? FTW_RECIP[RECIP_HALF-1:0]
                                      : FTW_RECIP[RECIP_W-1:RECIP_HALF];
  assign prod   = 56'(val_r) * 56'(k_half);
  // product scaled by 2^-27, the remaining 2^-23 is the slice below
  assign sum    = hi_r + 56'(lo_r);

  always_comb begin
    busy_nxt      = busy_r;
    res_valid_nxt = res_valid_r;
    res_nxt       = res_r;
    val_nxt       = val_r;
    step_nxt      = step_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    if (res_valid_r && res_ready) begin
      res_valid_nxt = 1'b0;
    end
    if (busy_r) begin
      case (step_r)
        STEP_LO: begin
          lo_nxt   = prod[55:RECIP_HALF];
          step_nxt = STEP_HI;
        end
        STEP_HI: begin
          hi_nxt   = prod;
          step_nxt = STEP_SUM;
        end
        default: begin
          busy_nxt      = 1'b0;
          res_valid_nxt = 1'b1;
          res_nxt.data  = sum[54:23];
        end
      endcase
    end else if (accept) begin
      res_nxt.chan = chan;
      case (mode)
        MODE_FREQ: begin
          res_nxt.addr     = ADDR_FTW;
          res_nxt.last_idx = LAST_IDX_FTW;
          if (value >= DDS_CLK) begin
            res_nxt.data  = FTW_SAT;
            res_valid_nxt = 1'b1;
          end else begin
            busy_nxt = 1'b1;
            val_nxt  = value;
            step_nxt = STEP_LO;
          end
        end
        MODE_AMP: begin
          res_nxt.addr     = ADDR_ACR;
          res_nxt.last_idx = LAST_IDX_AMP;
          res_nxt.data     = {8'h00, value[15:0] | AMP_ENABLE, 8'h00};
          res_valid_nxt    = 1'b1;
        end
        MODE_PHASE: begin
          res_nxt.addr     = ADDR_POW;
          res_nxt.last_idx = LAST_IDX_POW;
          res_nxt.data     = {value[15:0], 16'h0000};
          res_valid_nxt    = 1'b1;
        end
        default: begin
          // unused mode, command dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      res_valid_r <= res_valid_nxt;
    end
    res_r  <= res_nxt;
    val_r  <= val_nxt;
    step_r <= step_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
  end

endmodule

/* rtl/dds_rws_queue.sv */
// ============================================================================
// dds_rws_queue
// Short frame queue between the command intake and the serialiser.
// ============================================================================
module dds_rws_queue import dds_rws_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  frame_t wr_data,
  input  logic   wr_valid,
  output logic   wr_ready,
  output frame_t rd_data,
  output logic   rd_valid,
  input  logic   rd_pop
);

  frame_t            ent_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_wr;
  logic              do_rd;

  assign wr_ready = cnt_r != QCNT_W'(QDEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = ent_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_wr) begin
      ent_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* rtl/dds_rws_back.sv */
// ============================================================================
// dds_rws_back
// Serialiser: shifts both frames of a command out MSB first, one bit per
// beat, through an output register.
// ============================================================================
module dds_rws_back import dds_rws_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  frame_t frame,
  input  logic   frame_valid,
  output logic   frame_pop,
  output logic   empty,
  input  logic   pop,
  output logic   data_bit,
  output logic   frame_end,
  output logic   last
);

  logic                active_r, active_nxt;
  logic [STREAM_W-1:0] sh_r, sh_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    last_r, last_nxt;
  logic                ob_valid_r, ob_valid_nxt;
  logic                ob_bit_r, ob_bit_nxt;
  logic                ob_fe_r, ob_fe_nxt;
  logic                ob_last_r, ob_last_nxt;

  logic at_end;
  logic advance;
  logic load;

  assign at_end    = idx_r == last_r;
  assign advance   = active_r && (!ob_valid_r || pop);
  assign load      = frame_valid && (!active_r || (advance && at_end));
  assign frame_pop = load;

  assign empty     = !ob_valid_r;
  assign data_bit  = ob_bit_r;
  assign frame_end = ob_fe_r;
  assign last      = ob_last_r;

  always_comb begin
    active_nxt   = active_r;
    sh_nxt       = sh_r;
    idx_nxt      = idx_r;
    last_nxt     = last_r;
    ob_valid_nxt = ob_valid_r;
    ob_bit_nxt   = ob_bit_r;
    ob_fe_nxt    = ob_fe_r;
    ob_last_nxt  = ob_last_r;
    if (ob_valid_r && pop) begin
      ob_valid_nxt = 1'b0;
    end
    if (advance) begin
      ob_valid_nxt = 1'b1;
      ob_bit_nxt   = sh_r[STREAM_W-1];
      ob_fe_nxt    = at_end || (idx_r == FRAME1_LAST);
      ob_last_nxt  = at_end;
      sh_nxt       = {sh_r[STREAM_W-2:0], 1'b0};
      idx_nxt      = idx_r + 1'b1;
      if (at_end) begin
        active_nxt = 1'b0;
      end
    end
    if (load) begin
      active_nxt = 1'b1;
      sh_nxt     = {ADDR_CSR, frame.chan, frame.addr, frame.data};
      idx_nxt    = '0;
      last_nxt   = frame.last_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      ob_valid_r <= 1'b0;
    end else begin
      active_r   <= active_nxt;
      ob_valid_r <= ob_valid_nxt;
    end
    sh_r      <= sh_nxt;
    idx_r     <= idx_nxt;
    last_r    <= last_nxt;
    ob_bit_r  <= ob_bit_nxt;
    ob_fe_r   <= ob_fe_nxt;
    ob_last_r <= ob_last_nxt;
  end

endmodule

/* rtl/dds_register_write_serializer.sv */
// ============================================================================
// dds_register_write_serializer
// Turns frequency, amplitude and phase commands into the MSB-first serial
// write frames of a DDS chip.
// ============================================================================
// Input queue side: present in_mode, in_channel_select and in_value with
// push; the command is taken on an edge where full is low. Mode 3 is
// taken and dropped.
// Result queue side: while empty is low one serial bit waits on out_data_bit
// with out_frame_end (chip select rises after it) and out_last (final bit
// of the command); pop takes it.
// A command yields 56 (frequency), 48 (amplitude) or 40 (phase) beats.
// For frequency values below the clock a three-step reciprocal multiply
// forms the tuning word; larger values give the saturated word.
// The command rate is set by the serialiser moving one bit per cycle
// while pop keeps up; the multiply and a two-frame queue run ahead of it,
// so a frequency command does not slow the stream once traffic is
// flowing. full rises while a tuning word is being formed or the queue
// is full.
// Synchronous reset empties the queue and drops any command in flight.
// If pop stays low the current bit holds and the block fills up and
// raises full; nothing is lost.
// ============================================================================
module dds_register_write_serializer import dds_rws_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_channel_select,
  input  logic [28:0] in_value,
  output logic        empty,
  input  logic        pop,
  output logic        out_data_bit,
  output logic        out_frame_end,
  output logic        out_last
);

  frame_t front_frame;
  logic   front_valid;
  logic   q_ready;
  frame_t q_frame;
  logic   q_valid;
  logic   q_pop;

  dds_rws_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .mode      (in_mode),
    .chan      (in_channel_select),
    .value     (in_value),
    .res       (front_frame),
    .res_valid (front_valid),
    .res_ready (q_ready)
  );

  dds_rws_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_data  (front_frame),
    .wr_valid (front_valid),
    .wr_ready (q_ready),
    .rd_data  (q_frame),
    .rd_valid (q_valid),
    .rd_pop   (q_pop)
  );

  dds_rws_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame       (q_frame),
    .frame_valid (q_valid),
    .frame_pop   (q_pop),
    .empty       (empty),
    .pop         (pop),
    .data_bit    (out_data_bit),
    .frame_end   (out_frame_end),
    .last        (out_last)
  );

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_last) |-> out_frame_end)
    else $error("final beat of a command does not end a frame");

  a_no_gap_in_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !out_last) |=> !empty)
    else $error("gap inside a command bit stream");
`endif

endmodule

/* tb/tb_dds_register_write_serializer.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_dds_register_write_serializer
// Drives frequency, amplitude, phase and unused-mode commands into the
// serialiser and checks every serial beat against a bit-level predictor.
// A short directed table covers the field extremes, the saturated tuning
// word and the amplitude and phase wrap. About a hundred random commands
// follow. Both queue sides idle at random, then neither idles.
// ============================================================================
module tb_dds_register_write_serializer;
  import dds_rws_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         N_RANDOM    = 100;
  localparam int         N_DIRECTED  = 20;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         DRAIN_WAIT  = 120;
  localparam int         MAX_REPORTS = 10;

  typedef struct packed {
    logic data_bit;
    logic frame_end;
    logic last;
  } beat_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  chan;
    logic [28:0] value;
    logic        typed;
    logic [31:0] word;
  } cmd_row_t;

  // typed rows carry the register word as it can be read off directly
  cmd_row_t directed_rows [N_DIRECTED] = '{
    '{MODE_FREQ,   8'h00, 29'd0,          1'b1, 32'h0000_0000},
    '{MODE_FREQ,   8'hFF, 29'd500000000,  1'b1, FTW_SAT},
    '{MODE_FREQ,   8'hA5, 29'h1FFF_FFFF,  1'b1, FTW_SAT},
    '{MODE_FREQ,   8'h5A, 29'd499999999,  1'b0, 32'h0},
    '{MODE_FREQ,   8'h0F, 29'd1,          1'b0, 32'h0},
    '{MODE_FREQ,   8'hF0, 29'd250000000,  1'b1, 32'h8000_0000},
    '{MODE_AMP,    8'h00, 29'd0,          1'b1, 32'h0000_1000},
    '{MODE_AMP,    8'hFF, 29'd1023,       1'b1, 32'h0000_13FF},
    '{MODE_AMP,    8'h55, 29'h0_FFFF,     1'b1, 32'h0000_FFFF},
    '{MODE_AMP,    8'hAA, 29'h1FFF_FFFF,  1'b1, 32'h0000_FFFF},
    '{MODE_AMP,    8'h3C, 29'h1_0000,     1'b1, 32'h0000_1000},
    '{MODE_PHASE,  8'h00, 29'd0,          1'b1, 32'h0000_0000},
    '{MODE_PHASE,  8'hFF, 29'd16383,      1'b1, 32'h0000_3FFF},
    '{MODE_PHASE,  8'hC3, 29'h1FFF_FFFF,  1'b1, 32'h0000_FFFF},
    '{MODE_PHASE,  8'h81, 29'h1_2345,     1'b1, 32'h0000_2345},
    '{MODE_UNUSED, 8'hFF, 29'h1FFF_FFFF,  1'b0, 32'h0},
    '{MODE_PHASE,  8'h7E, 29'h0_AAAA,     1'b1, 32'h0000_AAAA},
    '{MODE_UNUSED, 8'h00, 29'd0,          1'b0, 32'h0},
    '{MODE_FREQ,   8'h18, 29'd123456789,  1'b0, 32'h0},
    '{MODE_AMP,    8'h24, 29'h1_5555,     1'b1, 32'h0000_5555}
  };

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [1:0]  in_mode;
  logic [7:0]  in_channel_select;
  logic [28:0] in_value;
  logic        empty;
  logic        pop;
  logic        out_data_bit;
  logic        out_frame_end;
  logic        out_last;

  beat_t serial_beat_q[$];
  int    cycle_count;
  int    mismatch_count;
  int    beats_checked;
  int    frames_seen;
  int    cmd_count [4];
  int    push_idle_pct;
  int    pop_idle_pct;

  dds_register_write_serializer u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_mode           (in_mode),
    .in_channel_select (in_channel_select),
    .in_value          (in_value),
    .empty             (empty),
    .pop               (pop),
    .out_data_bit      (out_data_bit),
    .out_frame_end     (out_frame_end),
    .out_last          (out_last)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [31:0] register_word(logic [1:0] mode, logic [28:0] value);
    logic [63:0] scaled;
    scaled = {35'd0, value} << 32;
    case (mode)
      MODE_FREQ: begin
        if (value >= DDS_CLK) return FTW_SAT;
        return 32'(scaled / 64'(DDS_CLK));
      end
      MODE_AMP: return {16'd0, value[15:0] | AMP_ENABLE};
      default: return {16'd0, value[15:0]};
    endcase
  endfunction

  function automatic void queue_byte(logic [7:0] data, logic end_frame, logic end_cmd);
    beat_t b;
    for (int i = 7; i >= 0; i--) begin
      b.data_bit  = data[i];
      b.frame_end = (i == 0) && end_frame;
      b.last      = (i == 0) && end_cmd;
      serial_beat_q.push_back(b);
    end
  endfunction

  function automatic void queue_command(logic [1:0] mode, logic [7:0] chan,
                                        logic [31:0] word);
    logic [7:0] addr;
    int         nbytes;
    case (mode)
      MODE_FREQ: begin
        addr   = ADDR_FTW;
        nbytes = 4;
      end
      MODE_AMP: begin
        addr   = ADDR_ACR;
        nbytes = 3;
      end
      default: begin
        addr   = ADDR_POW;
        nbytes = 2;
      end
    endcase
    queue_byte(ADDR_CSR, 1'b0, 1'b0);
    queue_byte(chan, 1'b1, 1'b0);
    queue_byte(addr, 1'b0, 1'b0);
    for (int k = nbytes - 1; k >= 0; k--)
      queue_byte(word[8*k +: 8], k == 0, k == 0);
  endfunction

  task automatic send_command(logic [1:0] mode, logic [7:0] chan, logic [28:0] value,
                              logic typed, logic [31:0] word);
    while ($urandom_range(99) < push_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push              <= 1'b1;
    in_mode           <= mode;
    in_channel_select <= chan;
    in_value          <= value;
    do @(posedge clk); while (full);
    cmd_count[mode]++;
    if (mode != MODE_UNUSED)
      queue_command(mode, chan, typed ? word : register_word(mode, value));
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // result side: random pop with a check of every beat taken
  always @(posedge clk) begin
    beat_t want;
    if (rst_n && pop && !empty) begin
      beats_checked++;
      if (out_frame_end) frames_seen++;
      if (serial_beat_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected beat: data_bit %0b frame_end %0b last %0b",
                   out_data_bit, out_frame_end, out_last);
      end else begin
        want = serial_beat_q.pop_front();
        if (want.data_bit !== out_data_bit || want.frame_end !== out_frame_end ||
            want.last !== out_last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("beat %0d mismatch: expected %0b/%0b/%0b got %0b/%0b/%0b",
                     beats_checked, want.data_bit, want.frame_end, want.last,
                     out_data_bit, out_frame_end, out_last);
        end
      end
    end
    pop <= ($urandom_range(99) >= pop_idle_pct);
  end

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("dds_register_write_serializer test failed");
    $finish;
  end

  initial begin
    logic [1:0]  mode;
    logic [28:0] value;
    int          pick;
    cycle_count       = 0;
    mismatch_count    = 0;
    beats_checked     = 0;
    frames_seen       = 0;
    cmd_count         = '{default: 0};
    push_idle_pct     = 35;
    pop_idle_pct      = 48;
    rst_n             = 1'b0;
    push              = 1'b0;
    pop               = 1'b0;
    in_mode           = MODE_FREQ;
    in_channel_select = 8'h00;
    in_value          = 29'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_command(directed_rows[i].mode, directed_rows[i].chan, directed_rows[i].value,
                   directed_rows[i].typed, directed_rows[i].word);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) begin
        push_idle_pct = 48;
        pop_idle_pct  = 35;
      end else if (i == 2 * N_RANDOM / 3) begin
        push_idle_pct = 0;
        pop_idle_pct  = 0;
      end
      pick = $urandom_range(99);
      mode = (pick < 35) ? MODE_FREQ : (pick < 65) ? MODE_AMP :
             (pick < 95) ? MODE_PHASE : MODE_UNUSED;
      pick = $urandom_range(99);
      case (mode)
        MODE_FREQ: begin
          if (pick < 80)      value = 29'($urandom_range(499999999, 0));
          else if (pick < 90) value = 29'($urandom_range(29'h1FFF_FFFF, 499999990));
          else                value = 29'($urandom_range(1000, 0));
        end
        MODE_AMP:   value = (pick < 70) ? 29'($urandom_range(1023, 0)) : 29'($urandom);
        MODE_PHASE: value = (pick < 70) ? 29'($urandom_range(16383, 0)) : 29'($urandom);
        default:    value = 29'($urandom);
      endcase
      send_command(mode, 8'($urandom), value, 1'b0, 32'h0);
    end
    push <= 1'b0;

    while (serial_beat_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("commands: %0d frequency, %0d amplitude, %0d phase, %0d unused mode",
             cmd_count[MODE_FREQ], cmd_count[MODE_AMP], cmd_count[MODE_PHASE],
             cmd_count[MODE_UNUSED]);
    $display("%0d serial beats in %0d frames checked, %0d mismatches, %0d cycles",
             beats_checked, frames_seen, mismatch_count, cycle_count);
    if (mismatch_count == 0 && serial_beat_q.size() == 0) begin
      $display("dds_register_write_serializer test passed");
    end else begin
      $display("dds_register_write_serializer test failed");
    end
    $finish;
  end

endmodule
